// ===== rtl/atbd_pkg.sv =====
// ----------------------------------------------------------------------------
// atbd_pkg
// Shared types and constants of the adaptive threshold beat detector.
// ----------------------------------------------------------------------------
package atbd_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 8;

	// multiplier operand width (Q0.16 ratio plus the one-point-zero bit)
	localparam int MUL_B_BITS = 17;
	localparam int Q16_SHIFT  = 16;

	localparam logic [15:0] RATE_NUM   = 16'd60000;
	localparam logic [15:0] RATE_LIMIT = 16'd25000;

	localparam logic [2:0] REG_RATIO   = 3'd0;
	localparam logic [2:0] REG_SMOOTH  = 3'd1;
	localparam logic [2:0] REG_DECAY   = 3'd2;
	localparam logic [2:0] REG_SWING   = 3'd3;
	localparam logic [2:0] REG_REFRACT = 3'd4;

	localparam logic [15:0] RATIO_RST   = 16'd45875;
	localparam logic [15:0] SMOOTH_RST  = 16'd3277;
	localparam logic [15:0] DECAY_RST   = 16'd1311;
	localparam logic [23:0] SWING_RST   = 24'd50;
	localparam logic [15:0] REFRACT_RST = 16'd300;

	typedef struct packed {
		logic start;
		logic clear;
	} mul_ctl_t;

endpackage

// ===== rtl/atbd_serial_mult.sv =====
// ----------------------------------------------------------------------------
// atbd_serial_mult
// Shift-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module atbd_serial_mult #(
	parameter int AW = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  atbd_pkg::mul_ctl_t                    ctl,
	input  logic [AW-1:0]                         a,
	input  logic [atbd_pkg::MUL_B_BITS-1:0]       b,
	output logic                                  busy,
	output logic [AW+atbd_pkg::MUL_B_BITS-1:0]    acc
);
	import atbd_pkg::*;

	localparam int PW = AW + MUL_B_BITS;

	logic [PW-1:0]         mc_q;
	logic [MUL_B_BITS-1:0] mr_q;
	logic [PW-1:0]         acc_q;
	logic [4:0]            cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= 5'(MUL_B_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mc_q <= PW'(a);
			mr_q <= b;
			if (ctl.clear) acc_q <= '0;
		end else if (cnt_q != '0) begin
			// add the shifted multiplicand where the multiplier bit is set
			if (mr_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mr_q <= {1'b0, mr_q[MUL_B_BITS-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign acc  = acc_q;

endmodule

// ===== rtl/atbd_serial_div.sv =====
// ----------------------------------------------------------------------------
// atbd_serial_div
// Restoring divider for the rate constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atbd_serial_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] quotient
);
	import atbd_pkg::*;

	logic [16:0] rem_q;
	logic [15:0] num_q;
	logic [15:0] quo_q;
	logic [15:0] d_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic        ge;

	assign trial = {rem_q[15:0], num_q[15]};
	assign ge    = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= RATE_NUM;
			quo_q <= '0;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (trial - {1'b0, d_q}) : trial;
			num_q <= {num_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

// ===== rtl/adaptive_threshold_beat_detector.sv =====
// ----------------------------------------------------------------------------
// adaptive_threshold_beat_detector
// Optical pulse beat detector with decaying trackers and adaptive threshold.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. Each item passes
// through these steps in order:
// - the target pass of the bit-serial multiplier: a start state, the bit
//   steps and a wait state that picks up the product;
// - the two blend passes;
// - the decision state;
// - the optional pass of the bit-serial divider for the rate;
// - the two tracker decay passes;
// - loading the output register.
// One item is processed at a time, and s_tready is high only while the block
// is idle. The next transaction is taken in the cycle after the previous
// result has moved into the output register, so the block never takes a new
// sample before it is through with the last one. A result that waits on
// m_tready stalls the block only when the next result is ready before it
// has left.
// beat and rate_valid travel in tuser; threshold and rate travel in tdata.
module adaptive_threshold_beat_detector #(
	parameter int SAMPLE_BITS = atbd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = atbd_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // sample[23:0], now_ms[55:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // beats_per_minute[15:0], current_threshold[47:16]
	output logic [1:0]  m_tuser   // beat[0], rate_valid[1]
);
	import atbd_pkg::*;

	localparam int VW = SAMPLE_BITS + FRAC_BITS;
	localparam int PW = VW + MUL_B_BITS;
	// width of the swing compare: the 24-bit minimum swing in Q.FRAC plus one
	localparam int SW = 24 + FRAC_BITS + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TGT, ST_TGT_W, ST_BL1, ST_BL1_W, ST_BL2, ST_BL2_W,
		ST_DEC, ST_DIV_W, ST_DMX, ST_DMX_W, ST_DMN, ST_DMN_W, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] ratio_q, smooth_q, decay_q, refract_q;
	logic [23:0] swing_min_q;

	// detector state
	logic [VW-1:0] max_q, min_q, thr_q, prev_q, cur_q, target_q;
	logic [31:0]   last_q, now_q;
	logic          have_q;

	// per-item results
	logic          beat_q, rate_ok_q;
	logic [15:0]   bpm_q;

	logic [VW-1:0] cur_in, swing;
	logic [VW:0]   blend_hi;
	logic [VW-1:0] thr_clamped;
	logic [31:0]   elapsed;
	logic          refract_ok, beat_now;

	mul_ctl_t              mul_ctl;
	logic [VW-1:0]         mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic                  mul_busy;
	logic [PW-1:0]         mul_acc;
	logic [VW-1:0]         mul_hi;
	logic                  div_start, div_busy;
	logic [15:0]           div_quo;

	assign cur_in = {s_tdata[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
	assign swing  = (max_q >= min_q) ? (max_q - min_q) : '0;
	assign mul_hi = mul_acc[VW+Q16_SHIFT-1:Q16_SHIFT];

	// clamp the blended threshold between the trackers
	assign blend_hi = mul_acc[PW-1:Q16_SHIFT];
	always_comb begin
		thr_clamped = blend_hi[VW-1:0];
		if (blend_hi < {1'b0, min_q}) thr_clamped = min_q;
		if (blend_hi > {1'b0, max_q}) thr_clamped = max_q;
	end

	assign elapsed    = now_q - last_q;
	assign refract_ok = !have_q || (elapsed > {16'd0, refract_q});
	assign beat_now   = (cur_q >= thr_q) && (prev_q < thr_q) && refract_ok &&
	                    (SW'(swing) > SW'({swing_min_q, {FRAC_BITS{1'b0}}}));

	// operand selection for the shared multiplier
	always_comb begin
		mul_ctl = '0;
		mul_a   = swing;
		mul_b   = {1'b0, ratio_q};
		case (state_q)
			ST_TGT: begin
				mul_ctl = '{start: 1'b1, clear: 1'b1};
			end
			ST_BL1: begin
				mul_ctl = '{start: 1'b1, clear: 1'b1};
				mul_a   = thr_q;
				mul_b   = 17'h10000 - {1'b0, smooth_q};
			end
			ST_BL2: begin
				mul_ctl = '{start: 1'b1, clear: 1'b0};
				mul_a   = target_q;
				mul_b   = {1'b0, smooth_q};
			end
			ST_DMX: begin
				mul_ctl = '{start: 1'b1, clear: 1'b1};
				mul_a   = max_q - cur_q;
				mul_b   = {1'b0, decay_q};
			end
			ST_DMN: begin
				mul_ctl = '{start: 1'b1, clear: 1'b1};
				mul_a   = cur_q - min_q;
				mul_b   = {1'b0, decay_q};
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == ST_DEC) && beat_now && have_q &&
	                   (elapsed <= {16'd0, RATE_NUM});

	atbd_serial_mult #(.AW(VW)) u_mult (
		.clk(clk), .arst_n(arst_n), .ctl(mul_ctl), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .acc(mul_acc)
	);

	atbd_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(elapsed[15:0]),
		.busy(div_busy), .quotient(div_quo)
	);

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RATIO_RST;
			smooth_q    <= SMOOTH_RST;
			decay_q     <= DECAY_RST;
			swing_min_q <= SWING_RST;
			refract_q   <= REFRACT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATIO:   ratio_q     <= cfg_data[15:0];
				REG_SMOOTH:  smooth_q    <= cfg_data[15:0];
				REG_DECAY:   decay_q     <= cfg_data[15:0];
				REG_SWING:   swing_min_q <= cfg_data;
				REG_REFRACT: refract_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// sequencer: state, detector state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_q     <= '0;
			min_q     <= '0;
			thr_q     <= '0;
			prev_q    <= '0;
			last_q    <= '0;
			have_q    <= 1'b0;
			m_tvalid  <= 1'b0;
			cur_q     <= '0;
			now_q     <= '0;
			target_q  <= '0;
			beat_q    <= 1'b0;
			rate_ok_q <= 1'b0;
			bpm_q     <= '0;
			m_tdata   <= '0;
			m_tuser   <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (m_tvalid && m_tready && state_q != ST_OUT) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						// trackers jump out to a new extreme at once
						cur_q <= cur_in;
						now_q <= s_tdata[55:24];
						if (cur_in > max_q) max_q <= cur_in;
						if (cur_in < min_q) min_q <= cur_in;
						state_q <= ST_TGT;
					end
				end
				ST_TGT:   state_q <= ST_TGT_W;
				ST_TGT_W: begin
					if (!mul_busy) begin
						target_q <= min_q + mul_hi;
						state_q  <= ST_BL1;
					end
				end
				ST_BL1:   state_q <= ST_BL1_W;
				ST_BL1_W: if (!mul_busy) state_q <= ST_BL2;
				ST_BL2:   state_q <= ST_BL2_W;
				ST_BL2_W: begin
					if (!mul_busy) begin
						thr_q   <= thr_clamped;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					beat_q    <= beat_now;
					rate_ok_q <= 1'b0;
					bpm_q     <= '0;
					if (beat_now) begin
						last_q <= now_q;
						have_q <= 1'b1;
					end
					state_q <= div_start ? ST_DIV_W : ST_DMX;
				end
				ST_DIV_W: begin
					if (!div_busy) begin
						if (div_quo != '0 && div_quo < RATE_LIMIT) begin
							rate_ok_q <= 1'b1;
							bpm_q     <= div_quo;
						end
						state_q <= ST_DMX;
					end
				end
				ST_DMX:   state_q <= ST_DMX_W;
				ST_DMX_W: begin
					if (!mul_busy) begin
						max_q   <= max_q - mul_hi;
						state_q <= ST_DMN;
					end
				end
				ST_DMN:   state_q <= ST_DMN_W;
				ST_DMN_W: begin
					if (!mul_busy) begin
						min_q   <= min_q + mul_hi;
						prev_q  <= cur_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {32'(thr_q), bpm_q};
						m_tuser  <= {rate_ok_q, beat_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a rate is only reported with a beat
	a_rate_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
		else $error("rate_valid without beat");

	// a reported rate lies strictly inside the range
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[15:0] != 16'd0 && m_tdata[15:0] < RATE_LIMIT))
		else $error("rate out of range");

	// trackers never cross
	a_track_order: assert property (@(posedge clk) disable iff (!arst_n)
		max_q >= min_q)
		else $error("max tracker below min tracker");

endmodule

// ===== tb/adaptive_threshold_beat_detector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_threshold_beat_detector_checker
// Watches the sample and result streams and the register port, predicts the
// threshold, beat and rate outputs of every accepted sample and compares them.
// ----------------------------------------------------------------------------
module adaptive_threshold_beat_detector_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          errors,
	output int          pending,
	output int          beats_seen,
	output int          rates_seen
);
	import atbd_pkg::*;

	typedef struct packed {
		logic        beat;
		logic        rate_valid;
		logic [15:0] bpm;
		logic [31:0] thr;
	} beat_result_t;

	logic [15:0] ratio, smooth, decay, refract;
	logic [23:0] swing_min;
	logic [31:0] max_tr, min_tr, thr_avg, prev_cur, last_beat;
	logic        have_beat;
	beat_result_t expected_q[$];

	function automatic logic [31:0] scale16(logic [31:0] v, logic [15:0] f);
		logic [47:0] p;
		p = {16'd0, v} * {32'd0, f};
		return p[47:16];
	endfunction

	task automatic predict_beat(input logic [23:0] smp, input logic [31:0] now);
		logic [31:0] cur, swing, target, thr, elapsed, r;
		logic [63:0] blend;
		beat_result_t res;
		cur = {smp, 8'd0};
		res = '0;
		if (cur > max_tr) max_tr = cur;
		if (cur < min_tr) min_tr = cur;
		swing = (max_tr >= min_tr) ? max_tr - min_tr : 32'd0;
		target = min_tr + scale16(swing, ratio);
		blend = {32'd0, thr_avg} * (64'd65536 - {48'd0, smooth})
			+ {32'd0, target} * {48'd0, smooth};
		thr = blend[47:16];
		if (thr < min_tr) thr = min_tr;
		if (thr > max_tr) thr = max_tr;
		thr_avg = thr;
		elapsed = now - last_beat;
		if (cur >= thr && prev_cur < thr && {32'd0, swing} > ({40'd0, swing_min} << 8)
			&& (!have_beat || elapsed > {16'd0, refract})) begin
			res.beat = 1'b1;
			if (have_beat && elapsed != 0) begin
				r = 32'd60000 / elapsed;
				if (r > 0 && r < 32'd25000) begin
					res.rate_valid = 1'b1;
					res.bpm = r[15:0];
				end
			end
			last_beat = now;
			have_beat = 1'b1;
		end
		max_tr = max_tr - scale16(max_tr - cur, decay);
		min_tr = min_tr + scale16(cur - min_tr, decay);
		prev_cur = cur;
		res.thr = thr;
		expected_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_result_t got, exp_r;
		if (!arst_n) begin
			ratio <= RATIO_RST; smooth <= SMOOTH_RST; decay <= DECAY_RST;
			swing_min <= SWING_RST; refract <= REFRACT_RST;
			max_tr = 0; min_tr = 0; thr_avg = 0; prev_cur = 0; last_beat = 0;
			have_beat = 0;
			expected_q.delete();
			errors <= 0; pending <= 0; beats_seen <= 0; rates_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_RATIO:   ratio <= cfg_data[15:0];
				REG_SMOOTH:  smooth <= cfg_data[15:0];
				REG_DECAY:   decay <= cfg_data[15:0];
				REG_SWING:   swing_min <= cfg_data;
				REG_REFRACT: refract <= cfg_data[15:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_beat(s_tdata[23:0], s_tdata[55:24]);
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tuser[1], m_tdata[15:0], m_tdata[47:16]};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch exp beat=%b rv=%b bpm=%0d thr=%h",
							$time, exp_r.beat, exp_r.rate_valid, exp_r.bpm, exp_r.thr);
						$display("%0t:          got beat=%b rv=%b bpm=%0d thr=%h",
							$time, got.beat, got.rate_valid, got.bpm, got.thr);
						errors <= errors + 1;
					end
					if (exp_r.beat) beats_seen <= beats_seen + 1;
					if (exp_r.rate_valid) rates_seen <= rates_seen + 1;
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/adaptive_threshold_beat_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_threshold_beat_detector_tb
// Drives pulse-like sample streams with timestamps through the detector over
// several register settings, with random stalls on both streams; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module adaptive_threshold_beat_detector_tb;
	import atbd_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	// an index past the last register, which the block must ignore
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // sample[23:0], now_ms[55:24]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // beats_per_minute[15:0], current_threshold[47:16]
	logic [1:0]  m_tuser;        // beat[0], rate_valid[1]
	int          errors, pending, beats_seen, rates_seen;
	int          cycles = 0;
	bit          calm = 1'b0;    // no idling once set
	int          items_sent = 0;
	logic [31:0] clock_ms;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	adaptive_threshold_beat_detector dut (.*);

	adaptive_threshold_beat_detector_checker u_checker (.*);

	// Watchdog: stop the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending);
			$display("adaptive_threshold_beat_detector_tb: done, errors");
			$finish;
		end
	end

	// Result side: stall in random bursts.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold one sample until the block takes it; idle first at random.
	// tvalid stays high afterwards; the next sample or wait_idle changes it.
	task automatic send_sample(input logic [23:0] smp, input logic [31:0] now);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Drain all results, then let the block settle before touching registers.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || s_tvalid) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// One pulse train: a rough sine-like wave with noise, period in samples.
	task automatic pulse_train(input int n, input int period, input int step_ms,
			input logic [23:0] base, input logic [23:0] amp);
		int ph, v;
		for (int k = 0; k < n; k++) begin
			ph = k % period;
			v = (ph < period / 2) ? ph : period - ph;
			v = base + (amp * v) / (period / 2 + 1) + $urandom_range(0, amp / 16 + 1);
			if (v > 24'hFFFFFF) v = 24'hFFFFFF;
			clock_ms += step_ms + $urandom_range(0, 2);
			send_sample(v[23:0], clock_ms);
		end
	endtask

	initial begin
		int sel;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, first beat without a previous one, wrap.
		clock_ms = 32'hFFFF_FF00;
		send_sample(24'd0, 32'd0);
		send_sample(24'hFFFFFF, 32'hFFFF_FFFF);
		send_sample(24'd0, clock_ms);
		send_sample(24'hFFFFFF, clock_ms + 400);      // crosses the wrap
		send_sample(24'd0, clock_ms + 500);
		send_sample(24'hFFFFFF, clock_ms + 501);      // inside refractory
		send_sample(24'd0, clock_ms + 900);
		send_sample(24'hFFFFFF, clock_ms + 70000);    // interval too long
		send_sample(24'h000000, clock_ms + 70100);
		send_sample(24'hFFFFFF, clock_ms + 71000);    // valid rate
		send_sample(24'h555555, clock_ms + 71100);
		send_sample(24'hAAAAAA, clock_ms + 71500);
		wait_idle();

		// Zero refractory and tiny intervals between samples.
		write_reg(REG_REFRACT, 24'd0);
		write_reg(REG_SWING, 24'd0);
		write_reg(REG_SMOOTH, 24'hFFFF);
		write_reg(REG_RATIO, 24'd0);
		write_reg(REG_DECAY, 24'hFFFF);
		write_reg(REG_UNUSED, 24'h123456);
		clock_ms = 32'd1000;
		for (int k = 0; k < 10; k++) begin
			clock_ms += (k % 3) + 1;
			send_sample((k % 2) ? 24'hFFFFFF : 24'd0, clock_ms);
		end
		wait_idle();

		// Random phases over several settings.
		for (int phase = 0; phase < 8; phase++) begin
			sel = phase % 4;
			write_reg(REG_RATIO, (sel == 0) ? 24'hFFFF : (sel == 1) ? 24'd0
				: 24'($urandom_range(20000, 60000)));
			write_reg(REG_SMOOTH, (sel == 2) ? 24'd0 : (sel == 3) ? 24'hFFFF
				: 24'($urandom_range(1000, 40000)));
			write_reg(REG_DECAY, (sel == 1) ? 24'd0 : 24'($urandom_range(0, 65535)));
			write_reg(REG_SWING, (phase == 5) ? 24'hFFFFFF : 24'($urandom_range(0, 200)));
			write_reg(REG_REFRACT, (phase == 6) ? 24'hFFFF
				: 24'($urandom_range(0, 600)));
			if (phase == 7) calm = 1'b1;
			for (int t = 0; t < 5; t++) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: arbitrary samples and times
					for (int k = 0; k < 40; k++)
						send_sample(24'($urandom()), $urandom());
				end else begin
					pulse_train(50, $urandom_range(4, 20), $urandom_range(5, 80),
						24'($urandom_range(0, 24'h7FFFFF)),
						24'($urandom_range(100, 24'h7FFFFF)));
				end
			end
			wait_idle();
		end

		$display("sent %0d samples over 10 register settings: %0d beats, %0d rates",
			items_sent, beats_seen, rates_seen);
		if (errors == 0) begin
			$display("adaptive_threshold_beat_detector_tb: done, clean");
		end else begin
			$display("adaptive_threshold_beat_detector_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== adaptive_threshold_beat_detector.f =====
rtl/atbd_pkg.sv
rtl/atbd_serial_mult.sv
rtl/atbd_serial_div.sv
rtl/adaptive_threshold_beat_detector.sv
tb/adaptive_threshold_beat_detector_checker.sv
tb/adaptive_threshold_beat_detector_tb.sv
